/* hdl/swept_aabb_collision_unit_defines.svh */
// Assertion macros for the swept box collision unit.
`ifndef SWEPT_AABB_COLLISION_UNIT_DEFINES_SVH
`define SWEPT_AABB_COLLISION_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
`define SACU_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sacu check failed");
`define SACU_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sacu check failed");
`else
`define SACU_ASSERT_NOW(lbl, clk, rst_n, ante, cons)
`define SACU_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

/* hdl/sacu_pkg.sv */
// Types and constants shared by the swept box collision unit.
package sacu_pkg;
    localparam int TIME_FRAC_BITS = 16;
    localparam int QUOT_W = TIME_FRAC_BITS + 2;
    localparam int TIME_W = TIME_FRAC_BITS + 3;
    localparam int DIFF_W = 17;
    localparam int ENTRY_W = 17;

    localparam logic signed [TIME_W-1:0] TIME_ONE = TIME_W'(2 ** TIME_FRAC_BITS);
    localparam logic signed [TIME_W-1:0] TIME_SAT = TIME_W'(2 ** (TIME_FRAC_BITS + 1));
    localparam logic signed [TIME_W-1:0] TIME_POS_INF = TIME_W'(2 ** (TIME_FRAC_BITS + 1) + 1);
    localparam logic signed [TIME_W-1:0] TIME_NEG_INF =
        TIME_W'(-(2 ** (TIME_FRAC_BITS + 1)) - 1);

    localparam int T_ENX = 0;
    localparam int T_EXX = 1;
    localparam int T_ENY = 2;
    localparam int T_EXY = 3;

    typedef enum logic [1:0] {
        SIDE_LEFT   = 2'd0,
        SIDE_RIGHT  = 2'd1,
        SIDE_TOP    = 2'd2,
        SIDE_BOTTOM = 2'd3
    } t_side;

    typedef struct packed {
        logic signed [15:0] moving_left;
        logic signed [15:0] moving_top;
        logic signed [15:0] moving_right;
        logic signed [15:0] moving_bottom;
        logic signed [15:0] moving_dx;
        logic signed [15:0] moving_dy;
        logic signed [15:0] other_left;
        logic signed [15:0] other_top;
        logic signed [15:0] other_right;
        logic signed [15:0] other_bottom;
        logic signed [15:0] other_dx;
        logic signed [15:0] other_dy;
    } t_in_item;

    typedef struct packed {
        logic                 hit;
        logic [ENTRY_W-1:0]   entry_time;
        logic [1:0]           side;
    } t_out_item;

    typedef struct packed {
        logic       bp_ok;
        logic       dx_zero;
        logic       dy_zero;
        logic       dx_pos;
        logic       dy_pos;
        logic [3:0] ovf;
        logic [3:0] neg;
    } t_div_ctrl;
endpackage

/* hdl/sacu_front.sv */
// Front stages: relative motion, broad phase, distances and divider set-up.
module sacu_front (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_en,
    input  logic                                  i_valid,
    input  sacu_pkg::t_in_item                    i_item,
    output logic                                  o_valid,
    output logic [3:0][sacu_pkg::DIFF_W-1:0]      o_num_mag,
    output logic [1:0][sacu_pkg::DIFF_W-1:0]      o_den_mag,
    output sacu_pkg::t_div_ctrl                   o_ctrl
);
    import sacu_pkg::*;

    logic                      r1_valid;
    t_in_item                  r1_item;
    logic signed [DIFF_W-1:0]  r1_dx, r1_dy;

    logic signed [DIFF_W:0]    ml, mt, mr, mb, ol, ot, orr, ob, mldx, mrdx, mtdy, mbdy;
    logic signed [DIFF_W:0]    bl, br, bt, bb;
    logic                      n_bp;
    logic signed [DIFF_W-1:0]  d_ol_mr, d_or_ml, d_ot_mb, d_ob_mt;
    logic [3:0][DIFF_W-1:0]    n_dist;

    logic                      r2_valid, r2_bp;
    logic [3:0][DIFF_W-1:0]    r2_dist;
    logic signed [DIFF_W-1:0]  r2_dx, r2_dy;

    logic [3:0][DIFF_W-1:0]    n_mag;
    logic [1:0][DIFF_W-1:0]    n_dmag;
    t_div_ctrl                 n_ctrl;

    logic                      r3_valid;
    logic [3:0][DIFF_W-1:0]    r3_num_mag;
    logic [1:0][DIFF_W-1:0]    r3_den_mag;
    t_div_ctrl                 r3_ctrl;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
            r2_valid <= 1'b0;
            r3_valid <= 1'b0;
        end else if (i_en) begin
            r1_valid <= i_valid;
            r2_valid <= r1_valid;
            r3_valid <= r2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_item <= i_item;
            r1_dx   <= DIFF_W'(i_item.moving_dx) - DIFF_W'(i_item.other_dx);
            r1_dy   <= DIFF_W'(i_item.moving_dy) - DIFF_W'(i_item.other_dy);
        end
    end

    always_comb begin
        ml   = (DIFF_W+1)'(r1_item.moving_left);
        mt   = (DIFF_W+1)'(r1_item.moving_top);
        mr   = (DIFF_W+1)'(r1_item.moving_right);
        mb   = (DIFF_W+1)'(r1_item.moving_bottom);
        ol   = (DIFF_W+1)'(r1_item.other_left);
        ot   = (DIFF_W+1)'(r1_item.other_top);
        orr  = (DIFF_W+1)'(r1_item.other_right);
        ob   = (DIFF_W+1)'(r1_item.other_bottom);
        mldx = ml + (DIFF_W+1)'(r1_dx);
        mrdx = mr + (DIFF_W+1)'(r1_dx);
        mtdy = mt + (DIFF_W+1)'(r1_dy);
        mbdy = mb + (DIFF_W+1)'(r1_dy);
        bl   = (mldx < ml) ? mldx : ml;
        br   = (mrdx > mr) ? mrdx : mr;
        bt   = (mtdy < mt) ? mtdy : mt;
        bb   = (mbdy > mb) ? mbdy : mb;
        n_bp = (bl <= orr) && (br >= ol) && (bt <= ob) && (bb >= ot);

        d_ol_mr = DIFF_W'(r1_item.other_left) - DIFF_W'(r1_item.moving_right);
        d_or_ml = DIFF_W'(r1_item.other_right) - DIFF_W'(r1_item.moving_left);
        d_ot_mb = DIFF_W'(r1_item.other_top) - DIFF_W'(r1_item.moving_bottom);
        d_ob_mt = DIFF_W'(r1_item.other_bottom) - DIFF_W'(r1_item.moving_top);

        if (r1_dx > 0) begin
            n_dist[T_ENX] = d_ol_mr;
            n_dist[T_EXX] = d_or_ml;
        end else begin
            n_dist[T_ENX] = d_or_ml;
            n_dist[T_EXX] = d_ol_mr;
        end
        if (r1_dy > 0) begin
            n_dist[T_ENY] = d_ot_mb;
            n_dist[T_EXY] = d_ob_mt;
        end else begin
            n_dist[T_ENY] = d_ob_mt;
            n_dist[T_EXY] = d_ot_mb;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r2_bp   <= n_bp;
            r2_dist <= n_dist;
            r2_dx   <= r1_dx;
            r2_dy   <= r1_dy;
        end
    end

    always_comb begin
        n_dmag[0] = r2_dx[DIFF_W-1] ? DIFF_W'(-r2_dx) : DIFF_W'(r2_dx);
        n_dmag[1] = r2_dy[DIFF_W-1] ? DIFF_W'(-r2_dy) : DIFF_W'(r2_dy);
        n_ctrl.dx_zero = (r2_dx == '0);
        n_ctrl.dy_zero = (r2_dy == '0);
        n_ctrl.dx_pos  = (r2_dx > 0);
        n_ctrl.dy_pos  = (r2_dy > 0);
        n_ctrl.bp_ok   = r2_bp && !(n_ctrl.dx_zero && n_ctrl.dy_zero);
        for (int i = 0; i < 4; i++) begin
            n_mag[i] = r2_dist[i][DIFF_W-1] ? DIFF_W'(-r2_dist[i]) : r2_dist[i];
            n_ctrl.neg[i] = r2_dist[i][DIFF_W-1] ^
                            ((i < 2) ? r2_dx[DIFF_W-1] : r2_dy[DIFF_W-1]);
            n_ctrl.ovf[i] = {2'b00, n_mag[i]} >= {n_dmag[(i < 2) ? 0 : 1], 2'b00};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r3_num_mag <= n_mag;
            r3_den_mag <= n_dmag;
            r3_ctrl    <= n_ctrl;
        end
    end

    assign o_valid   = r3_valid;
    assign o_num_mag = r3_num_mag;
    assign o_den_mag = r3_den_mag;
    assign o_ctrl    = r3_ctrl;
endmodule

/* hdl/sacu_divider.sv */
// Pipelined restoring divider, one quotient bit per stage.
module sacu_divider (
    input  logic                          i_clk,
    input  logic                          i_en,
    input  logic [sacu_pkg::DIFF_W-1:0]   i_num_mag,
    input  logic [sacu_pkg::DIFF_W-1:0]   i_den_mag,
    output logic [sacu_pkg::QUOT_W-1:0]   o_quot
);
    import sacu_pkg::*;

    logic [QUOT_W-1:0][DIFF_W-1:0] r_rem;
    logic [QUOT_W-1:0][DIFF_W-1:0] r_den;
    logic [QUOT_W-1:0][1:0]        r_lo;
    logic [QUOT_W-1:0][QUOT_W-1:0] r_quot;

    for (genvar k = 0; k < QUOT_W; k++) begin : g_stage
        localparam int J = QUOT_W - 1 - k;
        logic [DIFF_W-1:0] rem_in, den_in;
        logic [1:0]        lo_in;
        logic [QUOT_W-1:0] q_in;
        logic              nb;
        logic [DIFF_W:0]   trial;

        if (k == 0) begin : g_first
            assign rem_in = i_num_mag >> 2;
            assign den_in = i_den_mag;
            assign lo_in  = i_num_mag[1:0];
            assign q_in   = '0;
        end else begin : g_next
            assign rem_in = r_rem[k-1];
            assign den_in = r_den[k-1];
            assign lo_in  = r_lo[k-1];
            assign q_in   = r_quot[k-1];
        end

        if (J >= TIME_FRAC_BITS) begin : g_bit
            assign nb = lo_in[J-TIME_FRAC_BITS];
        end else begin : g_zero
            assign nb = 1'b0;
        end

        assign trial = {rem_in, nb};

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_den[k] <= den_in;
                r_lo[k]  <= lo_in;
                if (trial >= {1'b0, den_in}) begin
                    r_rem[k]  <= DIFF_W'(trial - {1'b0, den_in});
                    r_quot[k] <= {q_in[QUOT_W-2:0], 1'b1};
                end else begin
                    r_rem[k]  <= DIFF_W'(trial);
                    r_quot[k] <= {q_in[QUOT_W-2:0], 1'b0};
                end
            end
        end
    end

    assign o_quot = r_quot[QUOT_W-1];
endmodule

/* hdl/sacu_back.sv */
// Back stages: signed saturated times, hit decision and output register.
module sacu_back (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_en,
    input  logic                                  i_valid,
    input  logic [3:0][sacu_pkg::QUOT_W-1:0]      i_quot,
    input  sacu_pkg::t_div_ctrl                   i_ctrl,
    output logic                                  o_valid,
    output sacu_pkg::t_out_item                   o_result
);
    import sacu_pkg::*;

    function automatic logic signed [TIME_W-1:0] f_time(
        input logic [QUOT_W-1:0] quot,
        input logic              ovf,
        input logic              neg,
        input logic              zero,
        input logic              is_entry
    );
        logic signed [TIME_W-1:0] mag;
        mag = (ovf || (TIME_W'(quot) > TIME_SAT)) ? TIME_SAT : TIME_W'(quot);
        if (zero) begin
            f_time = is_entry ? TIME_NEG_INF : TIME_POS_INF;
        end else begin
            f_time = neg ? -mag : mag;
        end
    endfunction

    logic                            r_t_valid;
    logic [3:0][TIME_W-1:0]          r_t;
    t_div_ctrl                       r_ctrl;
    logic signed [TIME_W-1:0]        tenx, texx, teny, texy, tin, tout;
    logic                            miss;
    t_side                           n_side;
    logic                            r_valid;
    t_out_item                       r_result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_t_valid <= 1'b0;
            r_valid   <= 1'b0;
        end else if (i_en) begin
            r_t_valid <= i_valid;
            r_valid   <= r_t_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ctrl     <= i_ctrl;
            r_t[T_ENX] <= f_time(i_quot[T_ENX], i_ctrl.ovf[T_ENX], i_ctrl.neg[T_ENX],
                                 i_ctrl.dx_zero, 1'b1);
            r_t[T_EXX] <= f_time(i_quot[T_EXX], i_ctrl.ovf[T_EXX], i_ctrl.neg[T_EXX],
                                 i_ctrl.dx_zero, 1'b0);
            r_t[T_ENY] <= f_time(i_quot[T_ENY], i_ctrl.ovf[T_ENY], i_ctrl.neg[T_ENY],
                                 i_ctrl.dy_zero, 1'b1);
            r_t[T_EXY] <= f_time(i_quot[T_EXY], i_ctrl.ovf[T_EXY], i_ctrl.neg[T_EXY],
                                 i_ctrl.dy_zero, 1'b0);
        end
    end

    always_comb begin
        tenx = r_t[T_ENX];
        texx = r_t[T_EXX];
        teny = r_t[T_ENY];
        texy = r_t[T_EXY];
        tin  = (tenx > teny) ? tenx : teny;
        tout = (texx < texy) ? texx : texy;
        miss = !r_ctrl.bp_ok || (tenx < 0 && teny < 0) || (tenx > TIME_ONE) ||
               (teny > TIME_ONE) || (tin > tout);
        if (tenx > teny) begin
            n_side = r_ctrl.dx_pos ? SIDE_LEFT : SIDE_RIGHT;
        end else begin
            n_side = r_ctrl.dy_pos ? SIDE_TOP : SIDE_BOTTOM;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_result.hit        <= !miss;
            r_result.entry_time <= miss ? '0 : ENTRY_W'(tin);
            r_result.side       <= miss ? SIDE_LEFT : n_side;
        end
    end

    assign o_valid  = r_valid;
    assign o_result = r_result;
endmodule

/* hdl/swept_aabb_collision_unit.sv */
// Swept box collision unit, top level.
// Takes one box pair per clock while not stalled and returns one result per pair, in order.
// The pipeline has three front stages, an 18-stage restoring divider
// (one quotient bit per stage, four dividers side by side) and two back
// stages, the last being the output register. A stall on the output
// freezes the whole pipeline; the input is stalled only while a finished
// result waits to be taken.
`include "swept_aabb_collision_unit_defines.svh"
module swept_aabb_collision_unit (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_stall,
    input  sacu_pkg::t_in_item    i_item,
    output logic                  o_valid,
    input  logic                  i_stall,
    output sacu_pkg::t_out_item   o_result
);
    import sacu_pkg::*;

    logic                          en;
    logic                          front_valid;
    logic [3:0][DIFF_W-1:0]        num_mag;
    logic [1:0][DIFF_W-1:0]        den_mag;
    t_div_ctrl                     front_ctrl;
    logic [3:0][QUOT_W-1:0]        quot;
    logic [QUOT_W-1:0]             r_sb_valid;
    t_div_ctrl [QUOT_W-1:0]        r_sb_ctrl;

    assign o_stall = o_valid && i_stall;
    assign en      = !o_stall;

    sacu_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_en      (en),
        .i_valid   (i_valid),
        .i_item    (i_item),
        .o_valid   (front_valid),
        .o_num_mag (num_mag),
        .o_den_mag (den_mag),
        .o_ctrl    (front_ctrl)
    );

    for (genvar i = 0; i < 4; i++) begin : g_div
        sacu_divider u_div (
            .i_clk     (i_clk),
            .i_en      (en),
            .i_num_mag (num_mag[i]),
            .i_den_mag (den_mag[(i < 2) ? 0 : 1]),
            .o_quot    (quot[i])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sb_valid <= '0;
        end else if (en) begin
            r_sb_valid <= {r_sb_valid[QUOT_W-2:0], front_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_sb_ctrl <= {r_sb_ctrl[QUOT_W-2:0], front_ctrl};
        end
    end

    sacu_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (en),
        .i_valid  (r_sb_valid[QUOT_W-1]),
        .i_quot   (quot),
        .i_ctrl   (r_sb_ctrl[QUOT_W-1]),
        .o_valid  (o_valid),
        .o_result (o_result)
    );

    `SACU_ASSERT_NOW(a_hit_in_frame, i_clk, i_rst_n, o_valid && o_result.hit, o_result.entry_time <= ENTRY_W'(TIME_ONE))
    `SACU_ASSERT_NOW(a_miss_zero, i_clk, i_rst_n, o_valid && !o_result.hit, o_result.entry_time == '0 && o_result.side == SIDE_LEFT)
    `SACU_ASSERT_NEXT(a_stall_freeze, i_clk, i_rst_n, o_stall, $stable(r_sb_valid))
endmodule
